/* sv/trc_pkg.sv */
// ----------------------------------------------------------------------------
// trc_pkg
// Shared types, constants and the unreachable-code marker table for the
// traceroute reply classifier.
// ----------------------------------------------------------------------------
package trc_pkg;

  // Offsets into the packet never exceed 131, so 8 bits carry them
  localparam int OFS_BITS = 8;

  // Configuration port
  localparam int CFG_INDEX_BITS = 2;
  localparam int CFG_DATA_BITS  = 16;
  localparam logic [CFG_INDEX_BITS-1:0] REG_PROBE_IDENT = 2'd0;
  localparam logic [CFG_INDEX_BITS-1:0] REG_PROBE_SEQ   = 2'd1;

  // Fixed protocol values
  localparam logic [7:0] UDP_PROTO          = 8'd17;
  localparam logic [7:0] TYPE_ECHO_REPLY    = 8'd0;
  localparam logic [7:0] TYPE_UNREACH       = 8'd3;
  localparam logic [7:0] TYPE_TIME_EXCEEDED = 8'd11;
  localparam logic [7:0] CODE_IN_TRANSIT    = 8'd0;
  localparam logic [7:0] UNREACH_PORT       = 8'd3;

  // Offsets relative to the outer header end
  localparam logic [OFS_BITS-1:0] OFS_CODE       = 8'd1;
  localparam logic [OFS_BITS-1:0] OFS_INNER_HDR  = 8'd8;
  localparam logic [OFS_BITS-1:0] OFS_INNER_PROT = 8'd17;

  // Marker codes
  localparam logic [3:0] MARK_NONE    = 4'd0;
  localparam logic [3:0] MARK_CLEARED = 4'd1;
  localparam logic [3:0] MARK_N       = 4'd2;
  localparam logic [3:0] MARK_H       = 4'd3;
  localparam logic [3:0] MARK_X       = 4'd4;
  localparam logic [3:0] MARK_P       = 4'd5;
  localparam logic [3:0] MARK_F       = 4'd6;
  localparam logic [3:0] MARK_S       = 4'd7;
  localparam logic [3:0] MARK_V       = 4'd8;
  localparam logic [3:0] MARK_C       = 4'd9;
  localparam logic [3:0] MARK_OTHER   = 4'd10;

  // Fields gathered from one packet, as seen including the current byte
  typedef struct packed {
    logic [7:0]  msg_type;
    logic [7:0]  msg_code;
    logic [7:0]  inner_protocol;
    logic [15:0] src_port;
    logic [15:0] dst_port;
    logic        complete;
  } fields_t;

  // One classification result
  typedef struct packed {
    logic       matched;
    logic       final_hop;
    logic       reached_destination;
    logic [3:0] mark;
  } result_t;

  // Marker for a destination-unreachable code
  function automatic logic [3:0] unreach_mark(input logic [7:0] code);
    logic [3:0] m;
    unique case (code)
      8'd0, 8'd6, 8'd8, 8'd11: m = MARK_N;
      8'd1, 8'd7, 8'd12:       m = MARK_H;
      8'd9, 8'd10, 8'd13:      m = MARK_X;
      8'd2:                    m = MARK_P;
      8'd3:                    m = MARK_CLEARED;
      8'd4:                    m = MARK_F;
      8'd5:                    m = MARK_S;
      8'd14:                   m = MARK_V;
      8'd15:                   m = MARK_C;
      default:                 m = MARK_OTHER;
    endcase
    return m;
  endfunction

endpackage

/* sv/trc_capture.sv */
// ----------------------------------------------------------------------------
// trc_capture
// Byte counter and per-packet field capture. Presents the field view that
// includes the byte being processed; clears everything after the last byte.
// ----------------------------------------------------------------------------
module trc_capture #(
  parameter int COUNT_BITS = 16
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             fire,
  input  logic [7:0]       pkt_byte,
  input  logic             pkt_last,
  output trc_pkg::fields_t fields
);
  import trc_pkg::*;

  localparam logic [COUNT_BITS-1:0] COUNT_MAX = {COUNT_BITS{1'b1}};

  logic [COUNT_BITS-1:0] byte_count;
  logic [5:0]            outer_header_len;
  logic [7:0]            msg_type_seen;
  logic [7:0]            msg_code_seen;
  logic [5:0]            inner_header_len;
  logic [7:0]            inner_protocol;
  logic [15:0]           quoted_src_port;
  logic [15:0]           quoted_dst_port;
  logic                  fields_complete;

  logic [COUNT_BITS-1:0] byte_count_next;
  logic [5:0]            outer_header_len_next;
  logic [7:0]            msg_type_seen_next;
  logic [7:0]            msg_code_seen_next;
  logic [5:0]            inner_header_len_next;
  logic [7:0]            inner_protocol_next;
  logic [15:0]           quoted_src_port_next;
  logic [15:0]           quoted_dst_port_next;
  logic                  fields_complete_next;

  logic [OFS_BITS-1:0]   ofs_type;
  logic [OFS_BITS-1:0]   ofs_inner;
  logic [OFS_BITS-1:0]   ofs_prot;
  logic [OFS_BITS-1:0]   ofs_quote;

  // Offset compares against the current byte position
  always_comb begin
    outer_header_len_next = (byte_count == '0) ? {pkt_byte[3:0], 2'b00} : outer_header_len;
    ofs_type  = OFS_BITS'(outer_header_len_next);
    ofs_inner = ofs_type + OFS_INNER_HDR;
    ofs_prot  = ofs_type + OFS_INNER_PROT;

    msg_type_seen_next = (byte_count == COUNT_BITS'(ofs_type)) ? pkt_byte : msg_type_seen;
    msg_code_seen_next = (byte_count == COUNT_BITS'(ofs_type + OFS_CODE)) ?
                         pkt_byte : msg_code_seen;
    inner_header_len_next = (byte_count == COUNT_BITS'(ofs_inner)) ?
                            {pkt_byte[3:0], 2'b00} : inner_header_len;
    inner_protocol_next = (byte_count == COUNT_BITS'(ofs_prot)) ? pkt_byte : inner_protocol;

    // Quoted UDP ports, high byte first
    ofs_quote = ofs_inner + OFS_BITS'(inner_header_len_next);
    quoted_src_port_next = quoted_src_port;
    quoted_dst_port_next = quoted_dst_port;
    if (byte_count == COUNT_BITS'(ofs_quote)) begin
      quoted_src_port_next = {pkt_byte, quoted_src_port[7:0]};
    end
    if (byte_count == COUNT_BITS'(ofs_quote + OFS_BITS'(1))) begin
      quoted_src_port_next = {quoted_src_port[15:8], pkt_byte};
    end
    if (byte_count == COUNT_BITS'(ofs_quote + OFS_BITS'(2))) begin
      quoted_dst_port_next = {pkt_byte, quoted_dst_port[7:0]};
    end
    if (byte_count == COUNT_BITS'(ofs_quote + OFS_BITS'(3))) begin
      quoted_dst_port_next = {quoted_dst_port[15:8], pkt_byte};
    end

    // All needed bytes seen once past both the protocol and the last port byte
    fields_complete_next = fields_complete |
                           ((byte_count >= COUNT_BITS'(ofs_prot)) &&
                            (byte_count >= COUNT_BITS'(ofs_quote + OFS_BITS'(3))));

    // Saturating position counter
    byte_count_next = (byte_count != COUNT_MAX) ? byte_count + COUNT_BITS'(1) : byte_count;
  end

  assign fields.msg_type       = msg_type_seen_next;
  assign fields.msg_code       = msg_code_seen_next;
  assign fields.inner_protocol = inner_protocol_next;
  assign fields.src_port       = quoted_src_port_next;
  assign fields.dst_port       = quoted_dst_port_next;
  assign fields.complete       = fields_complete_next;

  // Packet state: update per byte, clear after the last byte
  always_ff @(posedge clk) begin
    if (rst || (fire && pkt_last)) begin
      byte_count       <= '0;
      outer_header_len <= '0;
      msg_type_seen    <= '0;
      msg_code_seen    <= '0;
      inner_header_len <= '0;
      inner_protocol   <= '0;
      quoted_src_port  <= '0;
      quoted_dst_port  <= '0;
      fields_complete  <= 1'b0;
    end else if (fire) begin
      byte_count       <= byte_count_next;
      outer_header_len <= outer_header_len_next;
      msg_type_seen    <= msg_type_seen_next;
      msg_code_seen    <= msg_code_seen_next;
      inner_header_len <= inner_header_len_next;
      inner_protocol   <= inner_protocol_next;
      quoted_src_port  <= quoted_src_port_next;
      quoted_dst_port  <= quoted_dst_port_next;
      fields_complete  <= fields_complete_next;
    end
  end

endmodule

/* sv/trc_classify.sv */
// ----------------------------------------------------------------------------
// trc_classify
// Decides whether the captured reply quotes the current probe and derives
// the final-hop flag, destination flag and unreachable marker.
// ----------------------------------------------------------------------------
module trc_classify (
  input  trc_pkg::fields_t fields,
  input  logic [15:0]      probe_ident_port,
  input  logic [15:0]      probe_seq_port,
  output trc_pkg::result_t result
);
  import trc_pkg::*;

  logic kind_ok;
  logic hit;
  logic is_unreach;

  // Accepted kinds: time exceeded in transit, unreachable, echo reply
  assign is_unreach = (fields.msg_type == TYPE_UNREACH);
  assign kind_ok = ((fields.msg_type == TYPE_TIME_EXCEEDED) &&
                    (fields.msg_code == CODE_IN_TRANSIT)) ||
                   is_unreach || (fields.msg_type == TYPE_ECHO_REPLY);

  assign hit = kind_ok && fields.complete && (fields.inner_protocol == UDP_PROTO) &&
               (fields.src_port == probe_ident_port) && (fields.dst_port == probe_seq_port);

  always_comb begin
    result.matched             = hit;
    result.final_hop           = hit && (fields.msg_type != TYPE_TIME_EXCEEDED);
    result.reached_destination = hit && is_unreach && (fields.msg_code == UNREACH_PORT);
    result.mark                = (hit && is_unreach) ? unreach_mark(fields.msg_code) : MARK_NONE;
  end

endmodule

/* sv/traceroute_reply_classifier_unit.sv */
// ----------------------------------------------------------------------------
// traceroute_reply_classifier_unit
// Classifies a received IPv4 packet, streamed one byte per transfer, as a
// traceroute reply to the current probe; one result per packet.
//
//   Channel  | Handshake          | Payload
//   ---------+--------------------+----------------------------------------
//   in       | in_valid/in_stall  | packet_byte, last_byte
//   out      | out_valid/out_stall| matched, final_hop, reached_destination,
//            |                    | mark
//   cfg      | cfg_we             | cfg_index, cfg_data
//
// One byte per cycle sustained while out is not stalled. A last byte
// transfer loads the input register; from there the capture/classify logic
// loads the result register, which then offers the result. Reset is
// synchronous and clears the packet state and both probe registers. A stall
// on out holds the result register and the input register; in_stall rises
// only when both are full and out is stalled.
// ----------------------------------------------------------------------------
module traceroute_reply_classifier_unit #(
  parameter int COUNT_BITS = 16
) (
  input  logic                                clk,
  input  logic                                rst,
  // input bytes
  input  logic                                in_valid,
  output logic                                in_stall,
  input  logic [7:0]                          packet_byte,
  input  logic                                last_byte,
  // results
  output logic                                out_valid,
  input  logic                                out_stall,
  output logic                                matched,
  output logic                                final_hop,
  output logic                                reached_destination,
  output logic [3:0]                          mark,
  // configuration
  input  logic                                cfg_we,
  input  logic [trc_pkg::CFG_INDEX_BITS-1:0]  cfg_index,
  input  logic [trc_pkg::CFG_DATA_BITS-1:0]   cfg_data
);
  import trc_pkg::*;

  logic        in_reg_valid;
  logic [7:0]  in_reg_byte;
  logic        in_reg_last;
  logic [15:0] probe_ident_port;
  logic [15:0] probe_seq_port;
  logic        advance;
  logic        fire;
  fields_t     fields;
  result_t     result_next;
  result_t     result;

  // Pipeline control
  assign advance  = !out_valid || !out_stall;
  assign fire     = in_reg_valid && advance;
  assign in_stall = in_reg_valid && !advance;

  // Probe registers
  always_ff @(posedge clk) begin
    if (rst) begin
      probe_ident_port <= '0;
      probe_seq_port   <= '0;
    end else if (cfg_we) begin
      if (cfg_index == REG_PROBE_IDENT) begin
        probe_ident_port <= cfg_data;
      end
      if (cfg_index == REG_PROBE_SEQ) begin
        probe_seq_port <= cfg_data;
      end
    end
  end

  // Input register
  always_ff @(posedge clk) begin
    if (rst) begin
      in_reg_valid <= 1'b0;
    end else if (!in_stall) begin
      in_reg_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && !in_stall) begin
      in_reg_byte <= packet_byte;
      in_reg_last <= last_byte;
    end
  end

  trc_capture #(
    .COUNT_BITS (COUNT_BITS)
  ) u_capture (
    .clk      (clk),
    .rst      (rst),
    .fire     (fire),
    .pkt_byte (in_reg_byte),
    .pkt_last (in_reg_last),
    .fields   (fields)
  );

  trc_classify u_classify (
    .fields           (fields),
    .probe_ident_port (probe_ident_port),
    .probe_seq_port   (probe_seq_port),
    .result           (result_next)
  );

  // Result register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (advance) begin
      out_valid <= fire && in_reg_last;
    end
  end

  always_ff @(posedge clk) begin
    if (fire && in_reg_last) begin
      result <= result_next;
    end
  end

  assign matched             = result.matched;
  assign final_hop           = result.final_hop;
  assign reached_destination = result.reached_destination;
  assign mark                = result.mark;

  // A new result only follows a processed last byte
  a_result_from_last: assert property (@(posedge clk) disable iff (rst)
    $rose(out_valid) |-> $past(in_reg_valid && in_reg_last))
    else $error("result appeared without a last byte");

  // Unmatched replies carry no flags and no marker
  a_unmatched_clean: assert property (@(posedge clk) disable iff (rst)
    (out_valid && !matched) |-> (!final_hop && !reached_destination && (mark == MARK_NONE)))
    else $error("unmatched reply with flags set");

  // Destination reached implies final hop with the cleared marker
  a_reached_consistent: assert property (@(posedge clk) disable iff (rst)
    (out_valid && reached_destination) |-> (matched && final_hop && (mark == MARK_CLEARED)))
    else $error("inconsistent destination result");

  // Any marker implies a final hop
  a_mark_final: assert property (@(posedge clk) disable iff (rst)
    (out_valid && (mark != MARK_NONE)) |-> final_hop)
    else $error("marker without final hop");

endmodule
